FILE: hw/rtl/rgb565_to_memory_lcd_3bit_packer_defines.svh
// Assertion macros used by the memory LCD packer checker.
// No dependencies; included by the checker file.
`ifndef RGB565_TO_MEMORY_LCD_3BIT_PACKER_DEFINES_SVH
`define RGB565_TO_MEMORY_LCD_3BIT_PACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCDPK_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("LCD packer check failed");

// Next-cycle implication, disabled during reset.
`define LCDPK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("LCD packer check failed");

`endif

FILE: hw/rtl/lcdpk_pkg.sv
// Types and constants for the RGB565 to 3-bit memory LCD packer.
// No dependencies; imported by the core, queue and top-level modules of the block.
`default_nettype none

package lcdpk_pkg;

    localparam int LINE_WIDTH      = 176;
    localparam int PIXELS_PER_WORD = 4;
    localparam int COL_W           = $clog2(LINE_WIDTH);
    localparam int SLOT_W          = $clog2(PIXELS_PER_WORD);
    localparam int WIN_W           = ((COL_W > 9) ? COL_W : 9) + 1;

    localparam logic [15:0] LINE_CMD_BASE = 16'h9000;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_X_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_WIDTH   = 3'd5;

    typedef struct packed {
        logic [7:0]  line_count;
        logic [7:0]  first_line;
        logic        fill_enable;
        logic [15:0] fill_color;
        logic [7:0]  fill_x_start;
        logic [7:0]  fill_width;
    } cfg_t;

    typedef struct packed {
        logic [15:0] word;
        logic        is_line_address;
        logic        is_terminator;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lcdpk_core.sv
// Per-pixel packing logic: column, line and accumulator state and result words.
// Depends on lcdpk_pkg.
`default_nettype none

module lcdpk_core
    import lcdpk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        process,
    input  wire logic [15:0] pixel,
    input  wire cfg_t        cfg,
    output push_t            push
);

    logic [COL_W-1:0] col_reg,  col_next;
    logic [7:0]       line_reg, line_next;
    logic [15:0]      acc_reg,  acc_next;

    logic              first;
    logic              eol;
    logic              in_win;
    logic              word_out;
    logic              term;
    logic [WIN_W-1:0]  col_wide;
    logic [WIN_W-1:0]  win_end;
    logic [15:0]       p;
    logic [SLOT_W-1:0] slot;
    logic [3:0]        nibble;
    logic [15:0]       acc_new;
    logic [7:0]        line_inc;
    result_t           cmd_res;
    result_t           word_res;
    result_t           term_res;
    logic [1:0]        count;

    always_comb
    begin
        first    = (col_reg == '0);
        eol      = (col_reg == COL_W'(LINE_WIDTH - 1));
        col_wide = WIN_W'(col_reg);
        win_end  = WIN_W'(cfg.fill_x_start) + WIN_W'(cfg.fill_width);
        in_win   = (col_wide >= WIN_W'(cfg.fill_x_start)) && (col_wide < win_end);

        if (cfg.fill_enable)
        begin
            p = in_win ? cfg.fill_color : 16'h0000;
        end
        else
        begin
            p = pixel;
        end

        slot     = col_reg[SLOT_W-1:0];
        nibble   = {p[15], p[10], p[4], 1'b0};
        acc_new  = acc_reg | (16'(nibble) << {SLOT_W'(PIXELS_PER_WORD - 1) - slot, 2'b00});
        word_out = (slot == SLOT_W'(PIXELS_PER_WORD - 1)) || eol;
        line_inc = line_reg + 8'd1;
        term     = eol && (line_inc == cfg.line_count);

        cmd_res.word             = LINE_CMD_BASE + 16'(cfg.first_line) + 16'(line_reg);
        cmd_res.is_line_address  = 1'b1;
        cmd_res.is_terminator    = 1'b0;
        cmd_res.last_of_run      = 1'b0;
        word_res.word            = acc_new;
        word_res.is_line_address = 1'b0;
        word_res.is_terminator   = 1'b0;
        word_res.last_of_run     = 1'b0;
        term_res.word            = 16'h0000;
        term_res.is_line_address = 1'b0;
        term_res.is_terminator   = 1'b1;
        term_res.last_of_run     = 1'b0;

        count = 2'(first) + 2'(word_out) + 2'(term);

        if (first)
        begin
            push.res0 = cmd_res;
        end
        else if (word_out)
        begin
            push.res0 = word_res;
        end
        else
        begin
            push.res0 = term_res;
        end
        push.res1 = (first && word_out) ? word_res : term_res;
        push.res0.last_of_run = (count == 2'd1);
        push.res1.last_of_run = 1'b1;
        push.count = process ? count : 2'd0;

        col_next  = eol ? '0 : col_reg + 1'b1;
        acc_next  = word_out ? 16'h0000 : acc_new;
        line_next = eol ? (term ? 8'd0 : line_inc) : line_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= 8'd0;
            acc_reg  <= 16'h0000;
        end
        else if (process)
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lcdpk_fifo.sv
// Small result queue taking up to two results a cycle and giving one.
// Depends on lcdpk_pkg.
`default_nettype none

module lcdpk_fifo
    import lcdpk_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire push_t push,
    input  wire logic  pop,
    output result_t    head,
    output logic       valid,
    output logic       room
);

    result_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic [PTR_W-1:0] wr_ptr_plus;

    always_comb
    begin
        wr_ptr_plus = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
        valid       = (count_reg != '0);
        room        = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
        head        = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_plus] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rgb565_to_memory_lcd_3bit_packer.sv
// Top level of the RGB565 to 3-bit memory LCD packer: configuration registers,
// input register, packing core and result queue. Depends on lcdpk_pkg,
// lcdpk_core and lcdpk_fifo.
//
// Usage: pixels arrive on the in_valid/in_stall channel, one RGB565 word per
// line column, LINE_WIDTH words per line. Result words leave on the
// out_valid/out_stall channel: a line command before each line, one packed
// word per four pixels, and a zero terminator after the last line of a frame.
// Configuration registers are written through cfg_write/cfg_index/cfg_data,
// which the user must do only while the block is idle; the block does not
// enforce this. Unknown indexes are ignored.
// The block accepts one pixel per cycle; a pixel that ends a frame gives two
// results, which the four-entry result queue absorbs over the following
// cycles. Input stalls only while the queue holds more than two results.
// Reset clears the column, line and accumulator state, empties the queue and
// loads the register reset values. When the receiver stalls, the queue fills
// and then the input register holds its pixel and in_stall rises.
`default_nettype none

module rgb565_to_memory_lcd_3bit_packer
    import lcdpk_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [15:0]          pixel,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [15:0]               word,
    output logic                      is_line_address,
    output logic                      is_terminator,
    output logic                      last_of_run
);

    cfg_t        cfg_reg;
    logic        pipe_valid_reg, pipe_valid_next;
    logic [15:0] pixel_reg;
    logic        accept;
    logic        process;
    logic        room;
    logic        pop;
    push_t       push;
    result_t     head;

    always_comb
    begin
        process         = pipe_valid_reg && room;
        in_stall        = pipe_valid_reg && !room;
        accept          = in_valid && !in_stall;
        pipe_valid_next = accept || (pipe_valid_reg && !process);
        pop             = out_valid && !out_stall;
        word            = head.word;
        is_line_address = head.is_line_address;
        is_terminator   = head.is_terminator;
        last_of_run     = head.last_of_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_count   <= 8'd176;
            cfg_reg.first_line   <= 8'd0;
            cfg_reg.fill_enable  <= 1'b0;
            cfg_reg.fill_color   <= 16'h0000;
            cfg_reg.fill_x_start <= 8'd0;
            cfg_reg.fill_width   <= 8'd176;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LINE_COUNT:   cfg_reg.line_count   <= cfg_data[7:0];
                CFG_FIRST_LINE:   cfg_reg.first_line   <= cfg_data[7:0];
                CFG_FILL_ENABLE:  cfg_reg.fill_enable  <= cfg_data[0];
                CFG_FILL_COLOR:   cfg_reg.fill_color   <= cfg_data;
                CFG_FILL_X_START: cfg_reg.fill_x_start <= cfg_data[7:0];
                CFG_FILL_WIDTH:   cfg_reg.fill_width   <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= 1'b0;
        end
        else
        begin
            pipe_valid_reg <= pipe_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pixel_reg <= pixel;
        end
    end

    lcdpk_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .process (process),
        .pixel   (pixel_reg),
        .cfg     (cfg_reg),
        .push    (push)
    );

    lcdpk_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .valid (out_valid),
        .room  (room)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/lcdpk_checker.sv
// Port-level checks for the RGB565 to 3-bit memory LCD packer, bound to the top.
// Depends on the assertion macros header.
`default_nettype none

`include "rgb565_to_memory_lcd_3bit_packer_defines.svh"

module lcdpk_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] word,
    input wire logic        is_line_address,
    input wire logic        is_terminator,
    input wire logic        last_of_run
);

    `LCDPK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(word) && $stable(last_of_run))
    `LCDPK_ASSERT_IMPLY(a_kind_exclusive, clk, rst_n, out_valid, !(is_line_address && is_terminator))
    `LCDPK_ASSERT_IMPLY(a_line_cmd, clk, rst_n, out_valid && is_line_address, (word[15:12] == 4'h9) && last_of_run)
    `LCDPK_ASSERT_IMPLY(a_terminator, clk, rst_n, out_valid && is_terminator, (word == 16'h0000) && last_of_run)

endmodule

bind rgb565_to_memory_lcd_3bit_packer lcdpk_checker u_lcdpk_checker (.*);

`default_nettype wire
